/* design/lsf_pkg.sv */
// Shared constants for the least-squares line fit.
// Result field widths and the byte-padded width of the result word.
// No dependencies.
package lsf_pkg;

   localparam int SLOPE_W     = 32;
   localparam int SERR_W      = 31;
   localparam int ICPT_W      = 32;
   localparam int IERR_W      = 31;
   localparam int CORR_W      = 16;
   localparam int RSP_COUNT_W = 13;
   localparam int RSP_BITS    = SLOPE_W + SERR_W + ICPT_W + IERR_W + CORR_W + RSP_COUNT_W;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;

endpackage

/* design/lsf_front.sv */
// Front end of the line fit: accumulates the sums one sample per cycle while the queue has room.
// Pushes a snapshot of the sums into the queue on the last sample.
// Depends on nothing but its parameters.
module lsf_front #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16,
   parameter int CW          = 13,
   parameter int SXW         = 29,
   parameter int SQW         = 46,
   parameter int FW          = 13 + 2 * 29 + 3 * 46,
   parameter int REQ_W       = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tlast,
   output logic             push,
   output logic [FW-1:0]    push_data,
   input  logic             queue_full
);

   logic        [CW-1:0]  count_ff, count_in;
   logic signed [SXW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [SQW-1:0] sxx_ff, sxx_in, sxy_ff, sxy_in, syy_ff, syy_in;
   logic signed [SAMPLE_BITS-1:0]   x, y;
   logic signed [2*SAMPLE_BITS-1:0] xx, xy, yy;
   logic        [CW-1:0]  count_nx;
   logic signed [SXW-1:0] sx_nx, sy_nx;
   logic signed [SQW-1:0] sxx_nx, sxy_nx, syy_nx;
   logic                  accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // Sample products for this word.
   always_comb begin
      x  = signed'(req_tdata[SAMPLE_BITS-1:0]);
      y  = signed'(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
      xx = x * x;
      xy = x * y;
      yy = y * y;
   end

   // Sums including this sample, unless the set is already full.
   always_comb begin
      count_nx = count_ff;
      sx_nx    = sx_ff;
      sy_nx    = sy_ff;
      sxx_nx   = sxx_ff;
      sxy_nx   = sxy_ff;
      syy_nx   = syy_ff;
      if (count_ff < CW'(MAX_SAMPLES)) begin
         count_nx = count_ff + 1'b1;
         sx_nx    = sx_ff + SXW'(x);
         sy_nx    = sy_ff + SXW'(y);
         sxx_nx   = sxx_ff + SQW'(xx);
         sxy_nx   = sxy_ff + SQW'(xy);
         syy_nx   = syy_ff + SQW'(yy);
      end
   end

   assign push      = accept && req_tlast;
   assign push_data = {count_nx, sx_nx, sy_nx, sxx_nx, sxy_nx, syy_nx};

   // Next sums: cleared after the last sample of a set.
   always_comb begin
      count_in = count_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sxx_in   = sxx_ff;
      sxy_in   = sxy_ff;
      syy_in   = syy_ff;
      if (accept) begin
         if (req_tlast) begin
            count_in = '0;
            sx_in    = '0;
            sy_in    = '0;
            sxx_in   = '0;
            sxy_in   = '0;
            syy_in   = '0;
         end else begin
            count_in = count_nx;
            sx_in    = sx_nx;
            sy_in    = sy_nx;
            sxx_in   = sxx_nx;
            sxy_in   = sxy_nx;
            syy_in   = syy_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sxx_ff   <= '0;
         sxy_ff   <= '0;
         syy_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         sxx_ff   <= sxx_in;
         sxy_ff   <= sxy_in;
         syy_ff   <= syy_in;
      end
   end

endmodule

/* design/lsf_queue.sv */
// Two-entry queue of sum snapshots between the front and back ends.
// Depends on nothing but its width parameter.
module lsf_queue #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output logic [W-1:0] pop_data
);

   logic [W-1:0] mem_ff [2];
   logic         wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]   fill_ff, fill_in;

   assign full     = (fill_ff == 2'd2);
   assign valid    = (fill_ff != 2'd0);
   assign pop_data = mem_ff[rd_ff];

   // Pointer and fill update.
   always_comb begin
      wr_in   = wr_ff ^ push;
      rd_in   = rd_ff ^ pop;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

/* design/lsf_mul.sv */
// Serial signed multiplier, one multiplier bit per cycle.
// Depends on nothing but its width parameter.
module lsf_mul #(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [W-1:0]   a,
   input  logic signed [W-1:0]   b,
   output logic                  done,
   output logic signed [2*W-1:0] prod
);

   localparam int NW = $clog2(W + 1);

   logic [2*W-1:0] mcand_ff, mcand_in, acc_ff, acc_in;
   logic [W-1:0]   mplier_ff, mplier_in;
   logic [NW-1:0]  cnt_ff, cnt_in;
   logic           neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [W-1:0]   a_mag, b_mag;

   assign a_mag = a[W-1] ? (~a + 1'b1) : a;
   assign b_mag = b[W-1] ? (~b + 1'b1) : b;
   assign done  = done_ff;
   assign prod  = neg_ff ? -signed'(acc_ff) : signed'(acc_ff);

   // Shift and add over the magnitudes.
   always_comb begin
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = {{W{1'b0}}, a_mag};
         mplier_in = b_mag;
         acc_in    = '0;
         cnt_in    = NW'(W);
         neg_in    = a[W-1] ^ b[W-1];
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

/* design/lsf_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its width parameter.
module lsf_div #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quo
);

   localparam int NW = $clog2(W + 1);

   logic [W:0]    rem_ff, rem_in;
   logic [W-1:0]  num_ff, num_in, den_ff, den_in, quo_ff, quo_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    trial;

   assign done = done_ff;
   assign quo  = quo_ff;

   // One shift, compare and subtract a cycle.
   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[W-1:0], num_ff[W-1]};
      if (start) begin
         rem_in  = '0;
         num_in  = num;
         den_in  = den;
         quo_in  = '0;
         cnt_in  = NW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == NW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

/* design/lsf_back.sv */
// Back end of the line fit: sequences the products, quotients and square root.
// Uses lsf_mul and lsf_div, and the result layout from lsf_pkg.
// Holds the result word until the consumer takes it.
module lsf_back
   import lsf_pkg::*;
#(
   parameter int CW  = 13,
   parameter int SXW = 29,
   parameter int SQW = 46,
   parameter int FW  = 13 + 2 * 29 + 3 * 46
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  logic [FW-1:0]         q_data,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   // The intercept numerator is a product of a linear sum and a square sum.
   localparam int MW = SXW + SQW + 2;
   localparam int PW = 2 * MW;
   localparam int DW = PW + 32;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_CHECK, ST_DIV, ST_SQRT, ST_CLIP, ST_DONE
   } state_type;

   state_type state_ff;
   logic signed [MW-1:0] n_ff, sx_ff, sy_ff, sxx_ff, sxy_ff, syy_ff;
   logic signed [MW-1:0] d_ff, nxy_ff, dy_ff, b_ff, t1_ff;
   logic [PW-1:0]        base_ff, nsq_ff;
   logic [DW-1:0]        q_ff;
   logic [3:0]           idx_ff;
   logic [15:0]          k_ff;
   logic [3:0]           bit_ff;
   logic                 mul_start_ff, div_start_ff;
   logic [SLOPE_W-1:0]   slope_ff;
   logic [SERR_W-1:0]    serr_ff;
   logic [ICPT_W-1:0]    icpt_ff;
   logic [IERR_W-1:0]    ierr_ff;
   logic [CORR_W-1:0]    corr_ff;
   logic [RSP_COUNT_W-1:0] cnt_ff;
   logic                 degen_ff;
   logic                 rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                 rsp_tuser_ff;

   logic [CW-1:0]         f_n;
   logic signed [SXW-1:0] f_sx, f_sy;
   logic signed [SQW-1:0] f_sxx, f_sxy, f_syy;
   logic signed [MW-1:0]  mul_a, mul_b;
   logic                  mul_done, div_done;
   logic signed [PW-1:0]  mul_prod;
   logic signed [MW-1:0]  diff, div_src;
   logic [MW-1:0]         div_mag;
   logic [DW-1:0]         div_num, div_den, div_quo, cap, qsat;
   logic                  div_neg;
   logic [31:0]           fix_val;
   logic [15:0]           trial_k;
   logic [31:0]           trial_sq;

   assign {f_n, f_sx, f_sy, f_sxx, f_sxy, f_syy} = q_data;
   assign pop        = (state_ff == ST_IDLE) && q_valid;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // Operand pairs of the product sequence.
   always_comb begin
      unique case (idx_ff)
         4'd0:    begin mul_a = n_ff;   mul_b = sxx_ff; end
         4'd1:    begin mul_a = sx_ff;  mul_b = sx_ff;  end
         4'd2:    begin mul_a = n_ff;   mul_b = sxy_ff; end
         4'd3:    begin mul_a = sx_ff;  mul_b = sy_ff;  end
         4'd4:    begin mul_a = n_ff;   mul_b = syy_ff; end
         4'd5:    begin mul_a = sy_ff;  mul_b = sy_ff;  end
         4'd6:    begin mul_a = sy_ff;  mul_b = sxx_ff; end
         4'd7:    begin mul_a = sxy_ff; mul_b = sx_ff;  end
         4'd8:    begin mul_a = d_ff;   mul_b = dy_ff;  end
         default: begin mul_a = nxy_ff; mul_b = nxy_ff; end
      endcase
   end

   assign diff = t1_ff - mul_prod[MW-1:0];

   // Quotient operands: rounded Q16.16 fits, then the correlation ratio.
   always_comb begin
      unique case (idx_ff)
         4'd0:    div_src = nxy_ff;
         4'd1:    div_src = n_ff;
         4'd2:    div_src = b_ff;
         default: div_src = sxx_ff;
      endcase
      div_neg = div_src[MW-1] && (idx_ff != 4'd4);
      div_mag = div_src[MW-1] ? (~div_src + 1'b1) : div_src;
      if (idx_ff == 4'd4) begin
         div_num = {2'b00, nsq_ff, 30'd0};
         div_den = {{(DW-PW){1'b0}}, base_ff};
      end else begin
         div_num = ({{(DW-MW){1'b0}}, div_mag} << 17) + {{(DW-MW){1'b0}}, d_ff};
         div_den = {{(DW-MW){1'b0}}, d_ff} << 1;
      end
   end

   // Saturate and apply the sign of a fit quotient.
   always_comb begin
      cap     = div_neg ? (DW'(1) << 31) : ((DW'(1) << 31) - 1'b1);
      qsat    = (div_quo > cap) ? cap : div_quo;
      fix_val = div_neg ? (32'd0 - qsat[31:0]) : qsat[31:0];
   end

   // Square root trial for one result bit.
   assign trial_k  = k_ff | (16'd1 << bit_ff);
   assign trial_sq = trial_k * trial_k;

   lsf_mul #(.W(MW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start_ff),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   lsf_div #(.W(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Sequencer, working registers and the result word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mul_start_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         idx_ff        <= 4'd0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  n_ff         <= MW'(signed'({1'b0, f_n}));
                  sx_ff        <= MW'(f_sx);
                  sy_ff        <= MW'(f_sy);
                  sxx_ff       <= MW'(f_sxx);
                  sxy_ff       <= MW'(f_sxy);
                  syy_ff       <= MW'(f_syy);
                  cnt_ff       <= RSP_COUNT_W'(f_n);
                  slope_ff     <= '0;
                  serr_ff      <= '0;
                  icpt_ff      <= '0;
                  ierr_ff      <= '0;
                  corr_ff      <= '0;
                  degen_ff     <= 1'b0;
                  idx_ff       <= 4'd0;
                  mul_start_ff <= 1'b1;
                  state_ff     <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mul_done) begin
                  unique case (idx_ff)
                     4'd1:    d_ff    <= diff;
                     4'd3:    nxy_ff  <= diff;
                     4'd5:    dy_ff   <= diff;
                     4'd7:    b_ff    <= diff;
                     4'd8:    base_ff <= mul_prod;
                     4'd9:    nsq_ff  <= mul_prod;
                     default: t1_ff   <= mul_prod[MW-1:0];
                  endcase
                  priority if (idx_ff == 4'd7) begin
                     state_ff <= ST_CHECK;
                  end else if (idx_ff == 4'd9) begin
                     idx_ff       <= 4'd4;
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_DIV;
                  end else begin
                     idx_ff       <= idx_ff + 1'b1;
                     mul_start_ff <= 1'b1;
                  end
               end
            end
            ST_CHECK: begin
               if (d_ff[MW-1] || (d_ff == '0)) begin
                  degen_ff <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff       <= 4'd0;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  unique case (idx_ff)
                     4'd0:    slope_ff <= fix_val;
                     4'd1:    serr_ff  <= fix_val[SERR_W-1:0];
                     4'd2:    icpt_ff  <= fix_val;
                     4'd3:    ierr_ff  <= fix_val[IERR_W-1:0];
                     default: q_ff     <= div_quo;
                  endcase
                  priority if (idx_ff == 4'd4) begin
                     k_ff     <= 16'd0;
                     bit_ff   <= 4'd15;
                     state_ff <= ST_SQRT;
                  end else if (idx_ff == 4'd3) begin
                     if (dy_ff[MW-1] || (dy_ff == '0)) begin
                        degen_ff <= 1'b1;
                        state_ff <= ST_DONE;
                     end else begin
                        idx_ff       <= 4'd8;
                        mul_start_ff <= 1'b1;
                        state_ff     <= ST_MUL;
                     end
                  end else begin
                     idx_ff       <= idx_ff + 1'b1;
                     div_start_ff <= 1'b1;
                  end
               end
            end
            ST_SQRT: begin
               if ({{(DW-32){1'b0}}, trial_sq} <= q_ff) begin
                  k_ff <= trial_k;
               end
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == 4'd0) begin
                  state_ff <= ST_CLIP;
               end
            end
            ST_CLIP: begin
               // Full negative correlation reaches -1; positive stops short of +1.
               if (nxy_ff[MW-1]) begin
                  corr_ff <= 16'd0 - ((k_ff > 16'd32768) ? 16'd32768 : k_ff);
               end else begin
                  corr_ff <= (k_ff > 16'd32767) ? 16'd32767 : k_ff;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff  <= RSP_DATA_W'({cnt_ff, corr_ff, ierr_ff,
                                                icpt_ff, serr_ff, slope_ff});
                  rsp_tuser_ff  <= degen_ff;
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* design/least_squares_line_fit.sv */
// Least-squares line fit. A sample word is taken every cycle while the sum queue has room.
// The sums of a set enter the queue when its last sample word is taken; the back end then
// works each fit through the serial multiplier and divider; degenerate fits finish earlier.
// Synchronous active-high reset clears the sums, the queue and the sequencer.
// Depends on lsf_pkg, lsf_front, lsf_queue and lsf_back.
module least_squares_line_fit
   import lsf_pkg::*;
#(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: sample_x, sample_y, zero padding.
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: slope, slope_error, intercept, intercept_error,
   // correlation, sample_count, zero padding.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Fields from bit 0: degenerate.
   output logic                  rsp_tuser
);

   localparam int REQ_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int CW    = $clog2(MAX_SAMPLES + 1);
   localparam int SXW   = SAMPLE_BITS + CW;
   localparam int SQW   = 2 * SAMPLE_BITS + CW + 1;
   localparam int FW    = CW + 2 * SXW + 3 * SQW;

   logic          push, queue_full, q_valid, pop;
   logic [FW-1:0] push_data, q_data;

   lsf_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CW          (CW),
      .SXW         (SXW),
      .SQW         (SQW),
      .FW          (FW),
      .REQ_W       (REQ_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   lsf_queue #(.W(FW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   lsf_back #(
      .CW  (CW),
      .SXW (SXW),
      .SQW (SQW),
      .FW  (FW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
